### hw/rtl/lsmm_pkg.sv
// Package for the Latin square Markov mover: item and result types, cube
// geometry, cell value codes, state and axis enums, and the cell address map.
// Depends on nothing.
package lsmm_pkg;

  localparam int ORDER   = 10;
  localparam int CELLS   = ORDER * ORDER * ORDER;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COORD_W = 4;
  localparam int CUBE_W  = 2;
  localparam int BUMPS   = 8;
  localparam int BUMP_W  = $clog2(BUMPS);

  localparam logic [CUBE_W-1:0] CV_ZERO = 2'b00;
  localparam logic [CUBE_W-1:0] CV_ONE  = 2'b01;
  localparam logic [CUBE_W-1:0] CV_NEG  = 2'b11;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] pick_row;
    logic [COORD_W-1:0] pick_col;
    logic [COORD_W-1:0] pick_sym;
    logic               coin_row;
    logic               coin_col;
    logic               coin_sym;
  } item_t;

  typedef struct packed {
    logic               moved;
    logic               is_proper;
    logic               found;
    logic [COORD_W-1:0] symbol;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CUBE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE_RD,
    ST_BASE_CHK,
    ST_SCAN,
    ST_BUMP_RD,
    ST_BUMP_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AX_ROW,
    AX_COL,
    AX_SYM
  } axis_t;

  localparam logic MODE_STEP = 1'b0;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c,
                                                  input logic [COORD_W-1:0] s);
    return ADDR_W'((int'(r) * ORDER + int'(c)) * ORDER + int'(s));
  endfunction

endpackage

### hw/rtl/lsmm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module lsmm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lsmm_ctrl.sv
// Sequencer of the mover: clearing pass, line scans, and the eight
// read-modify-write updates on the cube memory. Depends on lsmm_pkg.
module lsmm_ctrl import lsmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  logic              item_valid,
  output logic              item_ready,
  output result_t           res,
  output logic              res_valid,
  input  logic              res_ready,
  output mem_req_t          req,
  input  logic [CUBE_W-1:0] rdata
);

  localparam logic [COORD_W-1:0] LAST = COORD_W'(ORDER - 1);

  state_t state, state_next;
  axis_t  axis;

  logic [COORD_W-1:0] clr_r, clr_c, clr_s;
  logic [COORD_W-1:0] br, bc, bs;
  logic [COORD_W-1:0] ox, oy, oz;
  logic [COORD_W-1:0] bad_row, bad_col, bad_sym;
  logic [COORD_W-1:0] j, p_idx, pos, symbol;
  logic [BUMP_W-1:0]  bidx;
  logic               g_row, g_col, g_sym, rd_mode;
  logic               iss_done, p_vld, hit, improper, moved, found;

  logic [COORD_W:0]   clr_sum, clr_mod;
  logic               clr_last, clr_one;
  logic               pick_rc_ok, pick_ok;
  logic               data_one, gsel, hit_now, axis_end;
  logic [COORD_W-1:0] pos_now;
  logic [ADDR_W-1:0]  scan_addr, bump_addr;
  logic [CUBE_W-1:0]  bump_val;

  function automatic logic [CUBE_W-1:0] bump_sat(input logic [CUBE_W-1:0] v,
                                                 input logic up);
    logic signed [CUBE_W:0] sum;
    sum = $signed({v[CUBE_W-1], v}) + (up ? 3'sd1 : -3'sd1);
    if (sum > 3'sd1) begin
      return CV_ONE;
    end else if (sum < -3'sd1) begin
      return CV_NEG;
    end
    return sum[CUBE_W-1:0];
  endfunction

  assign clr_sum  = {1'b0, clr_r} + {1'b0, clr_c};
  assign clr_mod  = (clr_sum >= (COORD_W+1)'(ORDER)) ? clr_sum - (COORD_W+1)'(ORDER) : clr_sum;
  assign clr_one  = ({1'b0, clr_s} == clr_mod);
  assign clr_last = (clr_r == LAST) && (clr_c == LAST) && (clr_s == LAST);

  assign pick_rc_ok = (int'(item.pick_row) < ORDER) && (int'(item.pick_col) < ORDER);
  assign pick_ok    = pick_rc_ok && (int'(item.pick_sym) < ORDER);

  assign data_one = (rdata == CV_ONE);
  assign hit_now  = hit | (p_vld & data_one);
  assign pos_now  = (p_vld && data_one && (!hit || gsel)) ? p_idx : pos;
  assign axis_end = p_vld && (p_idx == LAST);

  always_comb begin
    case (axis)
      AX_ROW: begin
        scan_addr = cell_addr(j, bc, bs);
        gsel      = g_row;
      end
      AX_COL: begin
        scan_addr = cell_addr(br, j, bs);
        gsel      = g_col;
      end
      AX_SYM: begin
        scan_addr = cell_addr(br, bc, j);
        gsel      = g_sym;
      end
      default: begin
        scan_addr = cell_addr(br, bc, bs);
        gsel      = 1'b0;
      end
    endcase
  end

  // Bit 1 of the update index selects the other row, bit 0 the other column,
  // and the parity of the index the other symbol; the first four add one.
  assign bump_addr = cell_addr(bidx[1] ? ox : br, bidx[0] ? oy : bc, (^bidx) ? oz : bs);
  assign bump_val  = bump_sat(rdata, !bidx[BUMP_W-1]);

  assign item_ready = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE);

  always_comb begin
    res.moved     = moved;
    res.is_proper = !improper;
    res.found     = found;
    res.symbol    = symbol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.we     = 1'b0;
    req.waddr  = bump_addr;
    req.wdata  = bump_val;
    req.raddr  = scan_addr;
    case (state)
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = cell_addr(clr_r, clr_c, clr_s);
        req.wdata = clr_one ? CV_ONE : CV_ZERO;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          if (item.mode != MODE_STEP) begin
            state_next = pick_rc_ok ? ST_SCAN : ST_DONE;
          end else if (improper) begin
            state_next = ST_SCAN;
          end else begin
            state_next = pick_ok ? ST_BASE_RD : ST_DONE;
          end
        end
      end
      ST_BASE_RD: begin
        req.raddr  = cell_addr(br, bc, bs);
        state_next = ST_BASE_CHK;
      end
      ST_BASE_CHK: begin
        state_next = (rdata == CV_ZERO) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (axis_end) begin
          if (!hit_now && !rd_mode) begin
            state_next = ST_DONE;
          end else if (axis == AX_SYM) begin
            state_next = rd_mode ? ST_DONE : ST_BUMP_RD;
          end
        end
      end
      ST_BUMP_RD: begin
        req.raddr  = bump_addr;
        state_next = ST_BUMP_WR;
      end
      ST_BUMP_WR: begin
        req.we     = 1'b1;
        state_next = (bidx == BUMP_W'(BUMPS - 1)) ? ST_DONE : ST_BUMP_RD;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_r    <= '0;
      clr_c    <= '0;
      clr_s    <= '0;
      improper <= 1'b0;
      bad_row  <= '0;
      bad_col  <= '0;
      bad_sym  <= '0;
      j        <= '0;
      iss_done <= 1'b0;
      p_vld    <= 1'b0;
      hit      <= 1'b0;
      bidx     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_s == LAST) begin
            clr_s <= '0;
            if (clr_c == LAST) begin
              clr_c <= '0;
              clr_r <= clr_r + 1'b1;
            end else begin
              clr_c <= clr_c + 1'b1;
            end
          end else begin
            clr_s <= clr_s + 1'b1;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            rd_mode  <= (item.mode != MODE_STEP);
            moved    <= 1'b0;
            found    <= 1'b0;
            symbol   <= '0;
            j        <= '0;
            iss_done <= 1'b0;
            p_vld    <= 1'b0;
            hit      <= 1'b0;
            bidx     <= '0;
            if (item.mode != MODE_STEP) begin
              axis  <= AX_SYM;
              br    <= item.pick_row;
              bc    <= item.pick_col;
              bs    <= '0;
              g_row <= 1'b0;
              g_col <= 1'b0;
              g_sym <= 1'b0;
            end else if (improper) begin
              axis  <= AX_ROW;
              br    <= bad_row;
              bc    <= bad_col;
              bs    <= bad_sym;
              g_row <= item.coin_row;
              g_col <= item.coin_col;
              g_sym <= item.coin_sym;
            end else begin
              axis  <= AX_ROW;
              br    <= item.pick_row;
              bc    <= item.pick_col;
              bs    <= item.pick_sym;
              g_row <= 1'b1;
              g_col <= 1'b1;
              g_sym <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          p_vld <= !iss_done;
          p_idx <= j;
          pos   <= pos_now;
          if (axis_end) begin
            j        <= '0;
            iss_done <= 1'b0;
            hit      <= 1'b0;
            case (axis)
              AX_ROW: begin
                ox   <= pos_now;
                axis <= AX_COL;
              end
              AX_COL: begin
                oy   <= pos_now;
                axis <= AX_SYM;
              end
              default: begin
                oz <= pos_now;
              end
            endcase
            if (rd_mode) begin
              found  <= hit_now;
              symbol <= hit_now ? pos_now : '0;
            end
          end else begin
            hit <= hit_now;
            if (!iss_done) begin
              j <= j + 1'b1;
              if (j == LAST) begin
                iss_done <= 1'b1;
              end
            end
          end
        end
        ST_BUMP_WR: begin
          bidx <= bidx + 1'b1;
          if (bidx == BUMP_W'(BUMPS - 1)) begin
            moved    <= 1'b1;
            improper <= (bump_val == CV_NEG);
            if (bump_val == CV_NEG) begin
              bad_row <= ox;
              bad_col <= oy;
              bad_sym <= oz;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/latin_square_markov_mover.sv
// Top level of the Latin square Markov mover: sequencer, cube memory and
// result register. Depends on lsmm_pkg, lsmm_ram and lsmm_ctrl.
//
//   channel   direction  handshake                     payload
//   item      in         item_valid / item_ready       item_t
//   result    out        result_valid / result_ready   result_t
//
// A proper step runs a base cell check, three line scans on the single cube
// read port, and eight read-modify-write updates, each a read state and a
// write state. An improper step skips the base check.
// After reset a clearing pass loads the cyclic square.
// A new item is taken while the last result still waits in the output register.
module latin_square_markov_mover import lsmm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_ready,
  output result_t result,
  output logic    result_valid,
  input  logic    result_ready
);

  result_t           res;
  logic              res_valid, res_ready;
  mem_req_t          req;
  logic [CUBE_W-1:0] rdata;

  lsmm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .req        (req),
    .rdata      (rdata)
  );

  lsmm_ram #(
    .WIDTH (CUBE_W),
    .DEPTH (CELLS)
  ) u_cube (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

endmodule

### hw/rtl/lsmm_checker.sv
// Port-level checks of the Latin square Markov mover, bound to its top level.
// Depends on lsmm_pkg and latin_square_markov_mover.
module lsmm_checker import lsmm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input item_t   item,
  input logic    item_valid,
  input logic    item_ready,
  input result_t result,
  input logic    result_valid,
  input logic    result_ready
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid && !item_ready)
    else $error("result or item handshake active right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while one is in work");

  a_symbol_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> (int'(result.symbol) < ORDER) && !result.moved)
    else $error("found symbol out of range or found with a move");

  a_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.symbol == '0)
    else $error("symbol nonzero without a found symbol");

endmodule

bind latin_square_markov_mover lsmm_checker u_lsmm_checker (.*);
